@@ src/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  typedef struct packed {
    logic       push;
    logic [1:0] byte_sel;
    logic       count_inc;
    logic       load_len;
    logic       load_v;
    logic       round_en;
    logic [5:0] rnd;
    logic       add_en;
    logic       reinit;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_ge56;
  } dp_status_t;

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ src/sha256_in_if.sv @@
// Input channel: one command word with an optional message byte.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

@@ src/sha256_out_if.sv @@
// Output channel: one digest word with its position.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last, input ready);
  modport sink   (input valid, input digest_word, input word_index, input last, output ready);
endinterface

@@ src/sha256_datapath.sv @@
// Datapath: byte window, message schedule, round unit, chaining state and counters.
module sha256_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::dp_cmd_t     cmd,
  input  logic [7:0]              data_byte,
  output sha256_pkg::dp_status_t  status,
  output logic [31:0]             digest_word
);
  import sha256_pkg::*;

  word_t       win [16];
  word_t       v [8];
  word_t       chain [8];
  logic [60:0] byte_count;
  logic [5:0]  fill;
  logic [63:0] len_bits;

  logic [7:0]  push_byte;
  word_t       w_new;
  word_t       t1;
  word_t       t2;

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: push_byte = data_byte;
      SEL_PAD:  push_byte = PAD_BYTE;
      SEL_LEN:  push_byte = len_bits[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  assign w_new = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[cmd.rnd] + win[0];
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign status.fill_full = (fill == LAST_POS);
  assign status.fill_ge56 = (fill >= LEN_OFFSET);
  assign digest_word      = chain[cmd.out_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) chain[j] <= IV[j];
      byte_count <= '0;
      fill       <= '0;
    end else begin
      if (cmd.push) fill <= fill + 6'd1;
      if (cmd.count_inc) byte_count <= byte_count + 61'd1;
      if (cmd.add_en) begin
        for (int j = 0; j < 8; j++) chain[j] <= chain[j] + v[j];
      end
      if (cmd.reinit) begin
        for (int j = 0; j < 8; j++) chain[j] <= IV[j];
        byte_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int j = 0; j < 15; j++) win[j] <= {win[j][23:0], win[j+1][31:24]};
      win[15] <= {win[15][23:0], push_byte};
    end else if (cmd.round_en) begin
      for (int j = 0; j < 15; j++) win[j] <= win[j+1];
      win[15] <= w_new;
    end

    if (cmd.load_len) begin
      len_bits <= {byte_count, 3'b000};
    end else if (cmd.push && cmd.byte_sel == SEL_LEN) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end

    if (cmd.load_v) begin
      for (int j = 0; j < 8; j++) v[j] <= chain[j];
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

@@ src/sha256_ctrl.sv @@
// Controller: absorb, padding, round sequencing and digest output.
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_command,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              word_index,
  output logic                    last,
  input  sha256_pkg::dp_status_t  status,
  output sha256_pkg::dp_cmd_t     cmd
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] out_idx, out_idx_next;
  logic       padding, padding_next;
  logic       extra, extra_next;
  logic       first, first_next;
  logic       in_acc;

  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = (state == ST_OUT);
  assign word_index = out_idx;
  assign last       = (out_idx == LAST_WORD);

  always_comb begin
    state_next   = state;
    rnd_next     = rnd;
    out_idx_next = out_idx;
    padding_next = padding;
    extra_next   = extra;
    first_next   = first;
    cmd          = '0;
    cmd.rnd      = rnd;
    cmd.out_idx  = out_idx;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_ABSORB) begin
            cmd.push      = 1'b1;
            cmd.byte_sel  = SEL_DATA;
            cmd.count_inc = 1'b1;
            if (status.fill_full) begin
              cmd.load_v = 1'b1;
              rnd_next   = '0;
              state_next = ST_ROUND;
            end
          end else begin
            cmd.load_len = 1'b1;
            padding_next = 1'b1;
            extra_next   = status.fill_ge56;
            first_next   = 1'b1;
            state_next   = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push   = 1'b1;
        first_next = 1'b0;
        if (first) begin
          cmd.byte_sel = SEL_PAD;
        end else if (status.fill_ge56 && !extra) begin
          cmd.byte_sel = SEL_LEN;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (status.fill_full) begin
          cmd.load_v = 1'b1;
          rnd_next   = '0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 6'd1;
        if (rnd == LAST_ROUND) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (extra) begin
          extra_next = 1'b0;
          state_next = ST_PAD;
        end else begin
          out_idx_next = '0;
          state_next   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == LAST_WORD) begin
            cmd.reinit   = 1'b1;
            padding_next = 1'b0;
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd     <= '0;
      out_idx <= '0;
      padding <= 1'b0;
      extra   <= 1'b0;
      first   <= 1'b0;
    end else begin
      state   <= state_next;
      rnd     <= rnd_next;
      out_idx <= out_idx_next;
      padding <= padding_next;
      extra   <= extra_next;
      first   <= first_next;
    end
  end

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == LAST_ROUND) |=> (state == ST_ADD))
    else $error("round sequence did not end in the add step");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_command == CMD_ABSORB && status.fill_full)
      |=> (state == ST_ROUND && rnd == 6'd0))
    else $error("full block did not start compression at round zero");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input accepted while digest words pending");

  a_digest_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (state == ST_IDLE && !padding))
    else $error("controller did not return to idle after final word");

endmodule

@@ src/sha256_stream_hasher_top.sv @@
// Top level of the SHA-256 stream hasher.
// SHA-256 over a byte stream. The absorb word that completes a 64-byte
// block is followed by a busy period: 64 rounds on the single round unit,
// then a step that folds the result into the chaining state. A finish word
// pads one byte per cycle up to the block end and then runs the final
// compression, and pads and compresses one further block when fewer than
// nine bytes of room remain. The eight digest words then leave in order,
// one per cycle while the sink is ready, and input stays stalled until the
// last one is taken. The hasher then holds the initial vector and a zero
// length, ready for the next message.
module sha256_stream_hasher_top (
  input  logic         clk,
  input  logic         rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.word_index),
    .last       (out_ch.last),
    .status     (status),
    .cmd        (cmd)
  );

  sha256_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .status      (status),
    .digest_word (out_ch.digest_word)
  );

endmodule
